// File: rtl/mdiv_pkg.sv
// Shared types and constants for the scaled multiply-divide block.
`timescale 1ns / 1ps
`default_nettype none

package mdiv_pkg;

  // Default operand width.
  localparam int unsigned WidthDefault = 64;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  // Status from the sequencer to the top level.
  typedef struct packed {
    logic idle;  // ready for a new operand beat
    logic done;  // result waiting in the sequencer
  } seq_sts_t;

endpackage

`default_nettype wire

// File: rtl/mdiv_addsub.sv
// Shared adder/subtractor used by both the multiply and divide passes.
`timescale 1ns / 1ps
`default_nettype none

module mdiv_addsub #(
  parameter int unsigned WIDTH = 64
) (
  input  wire logic [WIDTH-1:0] op_a_i,
  input  wire logic [WIDTH-1:0] op_b_i,
  input  wire logic             sub_i,
  output logic      [WIDTH:0]   sum_o
);

  logic [WIDTH-1:0] op_b_x;

  // sum_o[WIDTH] is the carry out; on subtract it is high when op_a >= op_b.
  assign op_b_x = sub_i ? ~op_b_i : op_b_i;
  assign sum_o  = {1'b0, op_a_i} + {1'b0, op_b_x} + {{WIDTH{1'b0}}, sub_i};

endmodule

`default_nettype wire

// File: rtl/mdiv_seq.sv
// Sequencer and datapath: shift-add multiply, then restoring divide.
`timescale 1ns / 1ps
`default_nettype none

module mdiv_seq #(
  parameter int unsigned WIDTH = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [WIDTH-1:0]    multiplicand_i,
  input  wire logic [WIDTH-1:0]    multiplier_i,
  input  wire logic [WIDTH-1:0]    divisor_i,
  input  wire logic                res_ready_i,
  output mdiv_pkg::seq_sts_t       sts_o,
  output logic      [WIDTH-1:0]    quotient_o,
  output logic                     divide_by_zero_o
);

  import mdiv_pkg::*;

  localparam int unsigned CntW = $clog2(2 * WIDTH);

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [WIDTH-1:0]  a_q, a_d;
  logic [WIDTH-1:0]  c_q, c_d;
  logic [WIDTH-1:0]  hi_q, hi_d;
  logic [WIDTH-1:0]  lo_q, lo_d;
  logic [WIDTH-1:0]  rem_q, rem_d;
  logic              dz_q, dz_d;

  logic [WIDTH-1:0]  add_a;
  logic [WIDTH-1:0]  add_b;
  logic              add_sub;
  logic [WIDTH:0]    add_sum;
  logic [WIDTH-1:0]  rem_sh;
  logic              take;

  mdiv_addsub #(.WIDTH(WIDTH)) u_addsub (
    .op_a_i (add_a),
    .op_b_i (add_b),
    .sub_i  (add_sub),
    .sum_o  (add_sum)
  );

  // Divide step: shift next dividend bit into the partial remainder.
  assign rem_sh = {rem_q[WIDTH-2:0], hi_q[WIDTH-1]};
  // Subtract when the shifted-out bit was set or the remainder covers c.
  assign take   = rem_q[WIDTH-1] | add_sum[WIDTH];

  always_comb begin
    add_a   = hi_q;
    add_b   = lo_q[0] ? a_q : '0;
    add_sub = 1'b0;
    if (state_q == S_DIV) begin
      add_a   = rem_sh;
      add_b   = c_q;
      add_sub = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    a_d     = a_q;
    c_d     = c_q;
    hi_d    = hi_q;
    lo_d    = lo_q;
    rem_d   = rem_q;
    dz_d    = dz_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          a_d   = multiplicand_i;
          c_d   = divisor_i;
          hi_d  = '0;
          lo_d  = multiplier_i;
          rem_d = '0;
          cnt_d = CntW'(WIDTH - 1);
          if (divisor_i == '0) begin
            lo_d    = '1;
            dz_d    = 1'b1;
            state_d = S_DONE;
          end else begin
            dz_d    = 1'b0;
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        // Add a when the low multiplier bit is set, then shift the pair right.
        hi_d  = add_sum[WIDTH:1];
        lo_d  = {add_sum[0], lo_q[WIDTH-1:1]};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          cnt_d   = CntW'(2 * WIDTH - 1);
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        // Dividend shifts out at the top, quotient bits fill in at the bottom.
        rem_d = take ? add_sum[WIDTH-1:0] : rem_sh;
        hi_d  = {hi_q[WIDTH-2:0], lo_q[WIDTH-1]};
        lo_d  = {lo_q[WIDTH-2:0], take};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    c_q   <= c_d;
    hi_q  <= hi_d;
    lo_q  <= lo_d;
    rem_q <= rem_d;
    dz_q  <= dz_d;
  end

  assign sts_o.idle       = (state_q == S_IDLE);
  assign sts_o.done       = (state_q == S_DONE);
  assign quotient_o       = lo_q;
  assign divide_by_zero_o = dz_q;

endmodule

`default_nettype wire

// File: rtl/mul_div_64.sv
// An accepted beat runs the multiply pass (S_MUL), then the divide pass (S_DIV), to S_DONE;
// a zero divisor goes straight to S_DONE. The result then loads into the output register
// when it is empty or draining. One item at a time: the shared adder does WIDTH multiply
// steps then 2*WIDTH divide steps; in_ready_o is low while it works.
// Reset: rst_ni is asynchronous, active low; it idles the sequencer and empties
// the output register. Nothing else holds state between items.
`timescale 1ns / 1ps
`default_nettype none

module mul_div_64 #(
  parameter int unsigned WIDTH = mdiv_pkg::WidthDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [WIDTH-1:0] multiplicand_i,
  input  wire logic [WIDTH-1:0] multiplier_i,
  input  wire logic [WIDTH-1:0] divisor_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic      [WIDTH-1:0] quotient_o,
  output logic                  divide_by_zero_o
);

  import mdiv_pkg::*;

  seq_sts_t          sts;
  logic [WIDTH-1:0]  seq_quot;
  logic              seq_dz;
  logic              load;
  logic              out_valid_q, out_valid_d;
  logic [WIDTH-1:0]  quot_q;
  logic              dz_q;

  // Move the result into the output register when it is empty or draining.
  assign load       = sts.done & (~out_valid_q | out_ready_i);
  assign in_ready_o = sts.idle;

  mdiv_seq #(.WIDTH(WIDTH)) u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (in_valid_i & sts.idle),
    .multiplicand_i   (multiplicand_i),
    .multiplier_i     (multiplier_i),
    .divisor_i        (divisor_i),
    .res_ready_i      (load),
    .sts_o            (sts),
    .quotient_o       (seq_quot),
    .divide_by_zero_o (seq_dz)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      quot_q <= seq_quot;
      dz_q   <= seq_dz;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign quotient_o       = quot_q;
  assign divide_by_zero_o = dz_q;

endmodule

`default_nettype wire

// File: rtl/mdiv_chk.sv
// Port-level checker for the scaled multiply-divide block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mdiv_chk #(
  parameter int unsigned WIDTH = 64
) (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_o,
  input wire logic [WIDTH-1:0] divisor_i,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire logic [WIDTH-1:0] quotient_o,
  input wire logic             divide_by_zero_o
);

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(quotient_o) && $stable(divide_by_zero_o))
    else $error("result beat changed while stalled");

  // A zero divisor result carries an all-ones quotient.
  a_dz_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_by_zero_o |-> (quotient_o == {WIDTH{1'b1}}))
    else $error("divide-by-zero result without all-ones quotient");

  // Accepting an operand beat makes the block busy.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after an accepted beat");

  // A zero divisor never has to run the arithmetic passes.
  a_dz_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (divisor_i == '0) && !out_valid_o |=> ##1 out_valid_o)
    else $error("zero divisor result not delivered in two cycles");

endmodule

bind mul_div_64 mdiv_chk #(.WIDTH(WIDTH)) u_mdiv_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .divisor_i        (divisor_i),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .quotient_o       (quotient_o),
  .divide_by_zero_o (divide_by_zero_o)
);

`default_nettype wire

// File: verif/tb.sv
// Self-checking testbench for the mul_div_64 scaled multiply-divide block.
`timescale 1ns / 1ps

module tb;
  import mdiv_pkg::*;

  localparam int unsigned W       = WidthDefault;
  localparam int unsigned LATENCY = 3 * W + 2;
  localparam int unsigned HOLD_LEN = 1500;

  typedef struct {
    logic [W-1:0] quotient;
    logic         divide_by_zero;
  } scaled_quot_t;

  logic         clk_i          = 1'b0;
  logic         rst_ni         = 1'b0;
  logic         in_valid_i     = 1'b0;
  logic         in_ready_o;
  logic [W-1:0] multiplicand_i = '0;
  logic [W-1:0] multiplier_i   = '0;
  logic [W-1:0] divisor_i      = '0;
  logic         out_valid_o;
  logic         out_ready_i    = 1'b0;
  logic [W-1:0] quotient_o;
  logic         divide_by_zero_o;

  scaled_quot_t quot_q[$];
  int           errors        = 0;
  int           beats_in      = 0;
  int           results_seen  = 0;
  int           zero_div_seen = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           hold_cycles   = 0;

  mul_div_64 #(.WIDTH(W)) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .multiplicand_i   (multiplicand_i),
    .multiplier_i     (multiplier_i),
    .divisor_i        (divisor_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .quotient_o       (quotient_o),
    .divide_by_zero_o (divide_by_zero_o)
  );

  always #4 clk_i = ~clk_i;

  // Exact double-width product, then truncate the quotient to W bits.
  function automatic scaled_quot_t scaled_quotient(input logic [W-1:0] a, b, c);
    scaled_quot_t  r;
    logic [2*W-1:0] product;
    logic [2*W-1:0] full_q;
    if (c == '0) begin
      r.quotient       = '1;
      r.divide_by_zero = 1'b1;
    end else begin
      product          = {{W{1'b0}}, a} * {{W{1'b0}}, b};
      full_q           = product / {{W{1'b0}}, c};
      r.quotient       = full_q[W-1:0];
      r.divide_by_zero = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [W-1:0] rand_operand();
    logic [W-1:0] v;
    case ($urandom_range(9))
      0:       v = W'($urandom_range(255));
      1:       v = '1 - W'($urandom_range(255));
      2:       v = W'(1) << $urandom_range(W - 1);
      3:       v = W'($urandom);
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic logic [W-1:0] rand_divisor(input logic [W-1:0] a);
    logic [W-1:0] v;
    case ($urandom_range(19))
      0:             v = '0;
      1, 2, 3, 4, 5: v = a ^ W'($urandom_range(15));
      6, 7:          v = W'($urandom_range(1, 3));
      default:       v = rand_operand();
    endcase
    return v;
  endfunction

  // Drive one beat and block until it is taken. Called in the time step of a rising edge.
  task automatic send_op(input logic [W-1:0] a, b, c);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    multiplicand_i <= a;
    multiplier_i   <= b;
    divisor_i      <= c;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Drop valid, let every pending result come back, then let the datapath settle.
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (quot_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic run_random_batch(input int n);
    logic [W-1:0] a, b;
    for (int i = 0; i < n; i++) begin
      a = rand_operand();
      b = rand_operand();
      send_op(a, b, rand_divisor(a));
    end
  endtask

  task automatic test_directed_corners();
    send_op('0, '0, W'(1));
    send_op('1, '1, '1);
    send_op('1, '1, W'(1));        // quotient wraps
    send_op('1, '1, '0);           // zero divisor
    send_op('0, '0, '0);
    send_op('0, '1, '0);
    send_op('1, '0, '1);
    send_op(W'(1), W'(1), '1);
    send_op('1, W'(2), W'(1));
    send_op(W'(1) << (W - 1), W'(2), W'(1));
    send_op(W'(1) << (W / 2), W'(1) << (W / 2), W'(1));
    send_op('1, '1, W'(1) << (W - 1));
    send_op('1, '1, '1 - W'(1));
    send_op(W'(12345), W'(678), W'(3));
    send_op(W'(7), W'(7), W'(49));
    send_op(W'(7), W'(7), W'(50));
    send_op('1, W'(3), W'(2));
    send_op(W'(1), '1, '1);
    send_op({W/2{2'b10}}, {W/2{2'b01}}, {W/2{2'b11}});
    send_op({W/2{2'b01}}, {W/2{2'b10}}, '0);
    send_op('1 - W'(1), '1, '1);
    wait_drain();
  endtask

  task automatic test_streaming();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random_batch(170);
    wait_drain();
  endtask

  task automatic test_sender_gaps();
    send_idle_pct  = 73;
    recv_stall_pct = 0;
    run_random_batch(170);
    wait_drain();
  endtask

  task automatic test_receiver_stalls();
    send_idle_pct  = 0;
    recv_stall_pct = 73;
    run_random_batch(170);
    wait_drain();
  endtask

  task automatic test_mixed_gaps();
    send_idle_pct  = 28;
    recv_stall_pct = 28;
    run_random_batch(170);
    wait_drain();
  endtask

  // Hold the output side off so the block fills and stalls its input.
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(negedge clk_i);
    hold_cycles = HOLD_LEN;
    @(posedge clk_i);
    run_random_batch(16);
    wait_drain();
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ready_i <= 1'b0;
      hold_cycles--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : scoreboard
    scaled_quot_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        quot_q.push_back(scaled_quotient(multiplicand_i, multiplier_i, divisor_i));
        beats_in++;
      end
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (divide_by_zero_o) zero_div_seen++;
        if (quot_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing pending: quotient=%h divide_by_zero=%b",
                   $time, quotient_o, divide_by_zero_o);
        end else begin
          want = quot_q.pop_front();
          if (quotient_o !== want.quotient) begin
            errors++;
            $display("%0t: quotient mismatch: expected %h actual %h",
                     $time, want.quotient, quotient_o);
          end
          if (divide_by_zero_o !== want.divide_by_zero) begin
            errors++;
            $display("%0t: divide_by_zero mismatch: expected %b actual %b",
                     $time, want.divide_by_zero, divide_by_zero_o);
          end
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_corners();
    test_streaming();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_gaps();
    test_output_backpressure();
    if (quot_q.size() != 0) begin
      errors += quot_q.size();
      $display("%0t: %0d results never arrived", $time, quot_q.size());
    end
    $display("Covered %0d operand beats, %0d results checked, %0d with a zero divisor,",
             beats_in, results_seen, zero_div_seen);
    $display("across free-running, sender-gap, receiver-stall, mixed and long hold-off phases.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("%0t: timeout with %0d results pending", $time, quot_q.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
